FILE: design/lsf_pkg.sv
// Shared types and constants for the learning switch forwarding unit.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package lsf_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned MAX_PORTS   = 16;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned FILL_W      = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PORT_W      = 4;
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned MASK_W      = 16;
  localparam int unsigned NUM_PORTS_W = 5;

  typedef logic [PORT_W-1:0]      port_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [MASK_W-1:0]      mask_t;
  typedef logic [NUM_PORTS_W-1:0] num_ports_t;
  typedef logic [FILL_W-1:0]      fill_t;
  typedef logic [TABLE_DEPTH-1:0] hit_t;

  localparam num_ports_t NUM_PORTS_RESET = num_ports_t'(16);
  localparam num_ports_t MAX_PORTS_N     = num_ports_t'(MAX_PORTS);
  localparam fill_t      FILL_FULL       = fill_t'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    ACT_FILTER  = 2'd0,
    ACT_FLOOD   = 2'd1,
    ACT_FORWARD = 2'd2
  } action_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // latch the accepted request
    logic learn;     // source learning step
    logic load_out;  // register the forwarding decision
  } cmd_t;

endpackage

`default_nettype wire

FILE: design/lsf_frame_if.sv
// Request channel: one frame header with valid/ready handshake.
// Depends on lsf_pkg.
`default_nettype none

interface lsf_frame_if;
  logic           valid;
  logic           ready;
  lsf_pkg::port_t ingress_port;
  lsf_pkg::addr_t dest_address;
  lsf_pkg::addr_t source_address;

  modport source (output valid, output ingress_port, output dest_address,
                  output source_address, input ready);
  modport sink   (input valid, input ingress_port, input dest_address,
                  input source_address, output ready);
endinterface

`default_nettype wire

FILE: design/lsf_result_if.sv
// Result channel: forwarding decision with valid/ready handshake.
// Depends on lsf_pkg.
`default_nettype none

interface lsf_result_if;
  logic           valid;
  logic           ready;
  logic [1:0]     action;
  lsf_pkg::port_t egress_port;
  lsf_pkg::mask_t flood_mask;
  logic           learn_dropped;

  modport source (output valid, output action, output egress_port, output flood_mask,
                  output learn_dropped, input ready);
  modport sink   (input valid, input action, input egress_port, input flood_mask,
                  input learn_dropped, output ready);
endinterface

`default_nettype wire

FILE: design/lsf_ctrl.sv
// Sequencing controller: accept, learn, decide, with the result register handshake.
// Depends on lsf_pkg.
`default_nettype none

module lsf_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_ready_o,
  output      logic          out_valid_o,
  input  wire logic          out_ready_i,
  output      lsf_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LEARN  = 3'b010,
    S_DECIDE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_LEARN;
        end
      end
      S_LEARN: begin
        cmd_o.learn = 1'b1;
        state_d     = S_DECIDE;
      end
      S_DECIDE: begin
        // decision waits here until the result register can take it
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          in_ready_o     = 1'b1;
          if (in_valid_i) begin
            cmd_o.capture = 1'b1;
            state_d       = S_LEARN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: design/lsf_datapath.sv
// Datapath: request latch, station table with parallel compare, decision and
// result registers, port count register. Depends on lsf_pkg.
`default_nettype none

module lsf_datapath (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire lsf_pkg::cmd_t         cmd_i,
  input  wire logic                  cfg_we_i,
  input  wire lsf_pkg::num_ports_t   cfg_wdata_i,
  input  wire lsf_pkg::port_t        ingress_port_i,
  input  wire lsf_pkg::addr_t        dest_address_i,
  input  wire lsf_pkg::addr_t        source_address_i,
  output      logic [1:0]            action_o,
  output      lsf_pkg::port_t        egress_port_o,
  output      lsf_pkg::mask_t        flood_mask_o,
  output      logic                  learn_dropped_o
);

  // request latch
  lsf_pkg::port_t ing_q;
  lsf_pkg::addr_t dst_q, src_q;

  // station table
  lsf_pkg::hit_t  entry_valid_q;
  lsf_pkg::addr_t entry_addr_q [lsf_pkg::TABLE_DEPTH];
  lsf_pkg::port_t entry_port_q [lsf_pkg::TABLE_DEPTH];
  lsf_pkg::fill_t fill_q;
  logic           dropped_q;

  lsf_pkg::num_ports_t num_ports_q;

  // result register
  lsf_pkg::action_e action_q, action_d;
  lsf_pkg::port_t   egress_q, egress_d;
  lsf_pkg::mask_t   mask_q, mask_d;
  logic             res_dropped_q;

  lsf_pkg::hit_t       src_hit, dst_hit, pair_hit, first_oh;
  logic                table_full;
  lsf_pkg::num_ports_t n_flood;
  lsf_pkg::port_t      fwd_port;

  always_comb begin
    for (int i = 0; i < lsf_pkg::TABLE_DEPTH; i++) begin
      src_hit[i]  = entry_valid_q[i] && entry_addr_q[i] == src_q && entry_port_q[i] == ing_q;
      dst_hit[i]  = entry_valid_q[i] && entry_addr_q[i] == dst_q;
      pair_hit[i] = dst_hit[i] && entry_port_q[i] == ing_q;
    end
  end

  assign table_full = fill_q >= lsf_pkg::FILL_FULL;

  // lowest matching slot is the oldest entry
  assign first_oh = dst_hit & (~dst_hit + lsf_pkg::hit_t'(1));

  always_comb begin
    fwd_port = '0;
    for (int i = 0; i < lsf_pkg::TABLE_DEPTH; i++) begin
      fwd_port = fwd_port | (first_oh[i] ? entry_port_q[i] : lsf_pkg::port_t'(0));
    end
  end

  assign n_flood = (num_ports_q > lsf_pkg::MAX_PORTS_N) ? lsf_pkg::MAX_PORTS_N : num_ports_q;

  always_comb begin
    action_d = lsf_pkg::ACT_FILTER;
    egress_d = '0;
    mask_d   = '0;
    if (|pair_hit) begin
      action_d = lsf_pkg::ACT_FILTER;
    end else if (!(|dst_hit)) begin
      action_d = lsf_pkg::ACT_FLOOD;
      for (int i = 0; i < lsf_pkg::MASK_W; i++) begin
        mask_d[i] = (lsf_pkg::num_ports_t'(i) < n_flood) && (lsf_pkg::port_t'(i) != ing_q);
      end
    end else begin
      action_d = lsf_pkg::ACT_FORWARD;
      egress_d = fwd_port;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
      fill_q        <= '0;
      num_ports_q   <= lsf_pkg::NUM_PORTS_RESET;
    end else begin
      if (cfg_we_i) begin
        num_ports_q <= cfg_wdata_i;
      end
      if (cmd_i.learn && !(|src_hit) && !table_full) begin
        entry_valid_q[fill_q[lsf_pkg::IDX_W-1:0]] <= 1'b1;
        fill_q <= fill_q + lsf_pkg::fill_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ing_q <= ingress_port_i;
      dst_q <= dest_address_i;
      src_q <= source_address_i;
    end
    if (cmd_i.learn) begin
      dropped_q <= !(|src_hit) && table_full;
      if (!(|src_hit) && !table_full) begin
        entry_addr_q[fill_q[lsf_pkg::IDX_W-1:0]] <= src_q;
        entry_port_q[fill_q[lsf_pkg::IDX_W-1:0]] <= ing_q;
      end
    end
    if (cmd_i.load_out) begin
      action_q      <= action_d;
      egress_q      <= egress_d;
      mask_q        <= mask_d;
      res_dropped_q <= dropped_q;
    end
  end

  assign action_o        = action_q;
  assign egress_port_o   = egress_q;
  assign flood_mask_o    = mask_q;
  assign learn_dropped_o = res_dropped_q;

endmodule

`default_nettype wire

FILE: design/learning_switch_forwarding_unit.sv
// Learning switch forwarding unit: takes one frame header request and returns one
// decision (filter, flood with port mask, or forward to the oldest learned port).
// Each request passes through the learn state, which writes the source pair into the
// 16-entry station table, and then the decide state, which compares the destination
// against the updated table and registers the decision; a new request is taken in
// the decide state as that decision is registered, once the result side is free.
// The table is cleared at reset and never evicts; when full, new pairs are
// dropped and flagged. num_ports (reset 16) should only be written while idle.
// Depends on lsf_pkg, lsf_frame_if, lsf_result_if, lsf_ctrl and lsf_datapath.
`default_nettype none

module learning_switch_forwarding_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire lsf_pkg::num_ports_t cfg_wdata_i,
  lsf_frame_if.sink                frame_i,
  lsf_result_if.source             result_o
);

  lsf_pkg::cmd_t cmd;

  lsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (frame_i.valid),
    .in_ready_o  (frame_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd)
  );

  lsf_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .ingress_port_i   (frame_i.ingress_port),
    .dest_address_i   (frame_i.dest_address),
    .source_address_i (frame_i.source_address),
    .action_o         (result_o.action),
    .egress_port_o    (result_o.egress_port),
    .flood_mask_o     (result_o.flood_mask),
    .learn_dropped_o  (result_o.learn_dropped)
  );

endmodule

`default_nettype wire
